@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr) \
	`ASSERT_PROP(lbl, !(expr))

`endif

@@ hw/rtl/tdct_pkg.sv @@
`timescale 1ns / 1ps
package tdct_pkg;

	localparam int ACTION_W = 2;
	localparam int DUR_W    = 24;
	localparam int PRE_W    = 7;
	localparam int TOTAL_W  = 30;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 30'h3FFF_FFFF;

	localparam int MAX_TASKS_DEF     = 64;
	localparam int DURATION_BITS_DEF = 24;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_DECL   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PREREQ = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic decl;
		logic prereq;
		logic pass_init;
		logic issue;
		logic commit;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic last_issue;
		logic found;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/tdct_in_if.sv @@
`timescale 1ns / 1ps
interface tdct_in_if import tdct_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [DUR_W-1:0]    duration;
	logic [PRE_W-1:0]    prereq_task;

	modport source (output valid, action, duration, prereq_task, input ready);
	modport sink (input valid, action, duration, prereq_task, output ready);
endinterface

@@ hw/rtl/tdct_out_if.sv @@
`timescale 1ns / 1ps
interface tdct_out_if import tdct_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] total_time;
	logic               overflow;

	modport source (output valid, total_time, overflow, input ready);
	modport sink (input valid, total_time, overflow, output ready);
endinterface

@@ hw/rtl/tdct_ctrl.sv @@
`timescale 1ns / 1ps
module tdct_ctrl import tdct_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [ACTION_W-1:0] in_action,
	output logic                in_ready,
	input  stat_t               st,
	output cmd_t                cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_ROUND = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (in_action)
						ACT_DECL:   cmd.decl = 1'b1;
						ACT_PREREQ: cmd.prereq = 1'b1;
						ACT_RUN: begin
							if (st.count_zero) begin
								state_d = S_EMIT;
							end else begin
								cmd.pass_init = 1'b1;
								state_d       = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (st.last_issue) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_ROUND;
			S_ROUND: begin
				if (st.found) begin
					cmd.commit = 1'b1;
					state_d    = S_SCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ hw/rtl/tdct_dp.sv @@
`timescale 1ns / 1ps
module tdct_dp import tdct_pkg::*; #(
	parameter int MAX_TASKS     = MAX_TASKS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DUR_W-1:0]   duration,
	input  logic [PRE_W-1:0]   prereq_task,
	input  cmd_t               cmd,
	output stat_t              st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TOTAL_W-1:0] total_time,
	output logic               overflow
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int DB = DURATION_BITS;
	localparam int SW = ((DB > TOTAL_W) ? DB : TOTAL_W) + 1;

	// task table
	logic [DB-1:0]        rem_mem  [MAX_TASKS];
	logic [MAX_TASKS-1:0] mask_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] ready_q, wait_q;

	logic [CW-1:0]        count_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 ovf_q;
	logic [MAX_TASKS-1:0] last_mask_q;

	// scan pass
	logic [IW-1:0]        rd_idx_q, idx_s1, min_idx_q, clr_idx_q;
	logic                 valid_s1, found_q, clr_en_q;
	logic [DB-1:0]        rem_s1, min_q, sub_q;
	logic [MAX_TASKS-1:0] mask_s1;

	logic [TOTAL_W-1:0]   out_total_q;
	logic                 out_valid_q, out_ovf_q;

	logic                 full, pre_bad, decl_ok, pre_ok;
	logic [IW-1:0]        decl_idx, last_idx, pre_idx;
	logic [MAX_TASKS-1:0] pre_mask, clr_bit, mask_new;
	logic                 t_rdy, t_wt, rel, cand_v, better;
	logic [DB-1:0]        rem_new, cand;
	logic [SW-1:0]        sum;
	logic [TOTAL_W-1:0]   total_sat;

	// load decode
	assign full     = (count_q == CW'(MAX_TASKS));
	assign pre_bad  = (count_q == '0) || (prereq_task == '0)
		|| (32'(prereq_task) > 32'(MAX_TASKS));
	assign decl_ok  = cmd.decl && !full;
	assign pre_ok   = cmd.prereq && !pre_bad;
	assign decl_idx = count_q[IW-1:0];
	assign last_idx = IW'(count_q - CW'(1));
	assign pre_idx  = IW'(prereq_task - PRE_W'(1));
	assign pre_mask = last_mask_q | (MAX_TASKS'(1) << pre_idx);

	// per-task update: subtract, clear finished prerequisite, release
	assign t_rdy    = ready_q[idx_s1];
	assign t_wt     = wait_q[idx_s1];
	assign clr_bit  = clr_en_q ? (MAX_TASKS'(1) << clr_idx_q) : '0;
	assign mask_new = mask_s1 & ~clr_bit;
	assign rem_new  = rem_s1 - sub_q;
	assign rel      = valid_s1 && t_wt && (mask_new == '0);
	assign cand_v   = valid_s1 && (t_rdy || rel);
	assign cand     = t_rdy ? rem_new : rem_s1;
	assign better   = cand_v && (!found_q || (cand < min_q));

	// saturating total
	assign sum       = SW'(total_q) + SW'(min_q);
	assign total_sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (decl_ok) rem_mem[decl_idx] <= DB'(duration);
		else if (valid_s1 && t_rdy) rem_mem[idx_s1] <= rem_new;
		if (decl_ok) mask_mem[decl_idx] <= '0;
		else if (pre_ok) mask_mem[last_idx] <= pre_mask;
		else if (valid_s1 && t_wt) mask_mem[idx_s1] <= mask_new;
		rem_s1  <= rem_mem[rd_idx_q];
		mask_s1 <= mask_mem[rd_idx_q];
	end

	// task status bits, written before any read
	always_ff @(posedge clk) begin
		if (decl_ok) begin
			ready_q[decl_idx] <= 1'b1;
			wait_q[decl_idx]  <= 1'b0;
		end else if (pre_ok) begin
			ready_q[last_idx] <= 1'b0;
			wait_q[last_idx]  <= 1'b1;
		end else if (rel) begin
			ready_q[idx_s1] <= 1'b1;
			wait_q[idx_s1]  <= 1'b0;
		end else if (cmd.commit) begin
			ready_q[min_idx_q] <= 1'b0;
		end
	end

	// pass payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (better) begin
			min_q     <= cand;
			min_idx_q <= idx_s1;
		end
		if (cmd.pass_init) sub_q <= '0;
		else if (cmd.commit) begin
			sub_q     <= min_q;
			clr_idx_q <= min_idx_q;
		end
		if (decl_ok) last_mask_q <= '0;
		else if (pre_ok) last_mask_q <= pre_mask;
		if (cmd.emit) begin
			out_total_q <= total_q;
			out_ovf_q   <= ovf_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			clr_en_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.issue) rd_idx_q <= rd_idx_q + IW'(1);
			if (better) found_q <= 1'b1;
			if (decl_ok) count_q <= count_q + CW'(1);
			if ((cmd.decl && full) || (cmd.prereq && pre_bad)) ovf_q <= 1'b1;
			if (cmd.pass_init) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				clr_en_q <= 1'b0;
				total_q  <= '0;
			end
			if (cmd.commit) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				clr_en_q <= 1'b1;
				total_q  <= total_sat;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				total_q     <= '0;
				ovf_q       <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.count_zero = (count_q == '0);
	assign st.last_issue = (rd_idx_q == last_idx);
	assign st.found      = found_q;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign total_time = out_total_q;
	assign overflow   = out_ovf_q;

endmodule

@@ hw/rtl/task_dag_completion_time.sv @@
`timescale 1ns / 1ps
// Task set completion time.
// task_req (sink): a request declares a task (action 0, duration), adds a
// prerequisite to the latest task (action 1, one-based prereq_task), or runs
// the set (action 2). Action 3 is ignored. Loads are taken back to back.
// result (source): one item per run request with total_time (saturating at
// 2^30-1) and overflow (a load request since the last run was dropped).
// A run makes one pass over the task table per finished task plus a final
// pass; a pass reads the loaded tasks one at a time through the single
// read port of the task memories, and a run of an empty set makes no pass.
// task_req.ready is low while a run is in progress. Task state is cleared
// after each run.
// The result sits in an output register; if the receiver stalls, load
// requests are still taken, and a following run stops at its end until the
// register frees. Reset (arst_n low) empties the task set and drops any
// pending result; no clearing pass is needed.
module task_dag_completion_time import tdct_pkg::*; #(
	parameter int MAX_TASKS     = MAX_TASKS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tdct_in_if.sink     task_req,
	tdct_out_if.source  result
);

	cmd_t  cmd;
	stat_t st;

	tdct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (task_req.valid),
		.in_action (task_req.action),
		.in_ready  (task_req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tdct_dp #(
		.MAX_TASKS     (MAX_TASKS),
		.DURATION_BITS (DURATION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.duration    (task_req.duration),
		.prereq_task (task_req.prereq_task),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.total_time  (result.total_time),
		.overflow    (result.overflow)
	);

endmodule

@@ hw/rtl/tdct_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdct_checker import tdct_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [ACTION_W-1:0] in_action,
	input logic                out_valid,
	input logic                out_ready,
	input logic [TOTAL_W-1:0]  total_time,
	input logic                overflow
);

	// result held until taken
	`ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(total_time) && $stable(overflow))
	// a run request makes the block busy
	`ASSERT_PROP(a_run_busy, in_valid && in_ready && in_action == ACT_RUN |=> !in_ready)
	// a new result only appears at the end of a run
	`ASSERT_PROP(a_result_after_run, $rose(out_valid) |-> $past(!in_ready))
	// an idle block with no result pending shows none after a load request
	`ASSERT_NEVER(a_no_spurious, !$past(out_valid) && $past(in_ready) && out_valid)

endmodule

bind task_dag_completion_time tdct_checker u_tdct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (task_req.valid),
	.in_ready   (task_req.ready),
	.in_action  (task_req.action),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.total_time (result.total_time),
	.overflow   (result.overflow)
);
